[rtl/core/jmlc_pkg.sv]
`timescale 1ns / 1ps

package jmlc_pkg;

	localparam int unsigned DataW  = 8;
	localparam int unsigned LimitW = 10;
	localparam int unsigned CountW = 11;
	localparam int unsigned LenW   = 16;

	localparam logic [LimitW-1:0] ScanLimitReset = LimitW'(500);

	// Result status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INVALID    = 2'd1;
	localparam logic [1:0] ST_SCAN_LIMIT = 2'd2;

	// Byte values and marker codes.
	localparam logic [DataW-1:0] B_FF    = 8'hFF;
	localparam logic [DataW-1:0] B_00    = 8'h00;
	localparam logic [DataW-1:0] M_TEM   = 8'h01;
	localparam logic [DataW-1:0] M_SOF0  = 8'hC0;
	localparam logic [DataW-1:0] M_SOF2  = 8'hC2;
	localparam logic [DataW-1:0] M_DHT   = 8'hC4;
	localparam logic [DataW-1:0] M_SOF6  = 8'hC6;
	localparam logic [DataW-1:0] M_JPG   = 8'hC8;
	localparam logic [DataW-1:0] M_SOF10 = 8'hCA;
	localparam logic [DataW-1:0] M_DAC   = 8'hCC;
	localparam logic [DataW-1:0] M_SOF14 = 8'hCE;
	localparam logic [DataW-1:0] M_SOF15 = 8'hCF;
	localparam logic [DataW-1:0] M_RST0  = 8'hD0;
	localparam logic [DataW-1:0] M_RST7  = 8'hD7;
	localparam logic [DataW-1:0] M_SOI   = 8'hD8;
	localparam logic [DataW-1:0] M_EOI   = 8'hD9;
	localparam logic [DataW-1:0] M_SOS   = 8'hDA;

	typedef enum logic [8:0] {
		PH_SOI_FF     = 9'b0_0000_0001,
		PH_SOI_CODE   = 9'b0_0000_0010,
		PH_MARK_FF    = 9'b0_0000_0100,
		PH_MARK_CODE  = 9'b0_0000_1000,
		PH_LEN_HI     = 9'b0_0001_0000,
		PH_LEN_LO     = 9'b0_0010_0000,
		PH_SKIP       = 9'b0_0100_0000,
		PH_ENTROPY    = 9'b0_1000_0000,
		PH_ENTROPY_FF = 9'b1_0000_0000
	} phase_t;

	typedef struct packed {
		logic [DataW-1:0] data_byte;
		logic             last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       progressive;
	} result_t;

	function automatic logic is_frame_code(input logic [DataW-1:0] m);
		return (m inside {[M_SOF0:M_SOF15]}) && !(m inside {M_DHT, M_JPG, M_DAC});
	endfunction

	function automatic logic is_prog_code(input logic [DataW-1:0] m);
		return m inside {M_SOF2, M_SOF6, M_SOF10, M_SOF14};
	endfunction

endpackage

[rtl/core/jmlc_in_stage.sv]
`timescale 1ns / 1ps

module jmlc_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jmlc_pkg::in_item_t in_item,
	input  logic               consume,
	output logic               valid_s1,
	output jmlc_pkg::in_item_t item_s1
);
	import jmlc_pkg::*;

	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/core/jmlc_parser.sv]
`timescale 1ns / 1ps

module jmlc_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  jmlc_pkg::in_item_t              item,
	input  logic [jmlc_pkg::LimitW-1:0]     scan_limit,
	output logic                            res_valid,
	output jmlc_pkg::result_t               res
);
	import jmlc_pkg::*;

	phase_t            phase_q, phase_d;
	logic [DataW-1:0]  marker_q, marker_d;
	logic [DataW-1:0]  len_hi_q, len_hi_d;
	logic [LenW-1:0]   skip_q, skip_d;
	logic [CountW-1:0] count_q, count_d;
	logic              frame_q, frame_d;
	logic              prog_q, prog_d;
	logic              decided_q;

	logic              give;
	logic [1:0]        give_st;
	logic              give_pr;
	logic              do_marker;
	logic              do_seg;
	logic [LenW-1:0]   seg_len;
	logic [CountW-1:0] count_inc;
	logic [DataW-1:0]  b;

	assign b         = item.data_byte;
	assign seg_len   = {len_hi_q, b};
	assign count_inc = count_q + CountW'(1);

	always_comb begin
		phase_d   = phase_q;
		marker_d  = marker_q;
		len_hi_d  = len_hi_q;
		skip_d    = skip_q;
		count_d   = count_q;
		frame_d   = frame_q;
		prog_d    = prog_q;
		give      = 1'b0;
		give_st   = ST_OK;
		give_pr   = 1'b0;
		do_marker = 1'b0;
		do_seg    = 1'b0;

		if (!decided_q) begin
			case (phase_q)
				PH_SOI_FF: begin
					if (scan_limit == '0 || b != B_FF) begin
						give    = 1'b1;
						give_st = ST_INVALID;
					end else begin
						phase_d = PH_SOI_CODE;
					end
				end
				PH_SOI_CODE: begin
					if (b != B_FF) begin
						if (b != M_SOI) begin
							give    = 1'b1;
							give_st = ST_INVALID;
						end else begin
							phase_d = PH_MARK_FF;
						end
					end
				end
				PH_MARK_FF: begin
					if (b != B_FF) begin
						give    = 1'b1;
						give_st = ST_INVALID;
					end else begin
						phase_d = PH_MARK_CODE;
					end
				end
				PH_MARK_CODE: begin
					if (b == B_00) begin
						give    = 1'b1;
						give_st = ST_INVALID;
					end else if (b != B_FF) begin
						do_marker = 1'b1;
					end
				end
				PH_LEN_HI: begin
					len_hi_d = b;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (seg_len < LenW'(2)) begin
						give    = 1'b1;
						give_st = ST_INVALID;
					end else begin
						skip_d = seg_len - LenW'(2);
						if (seg_len == LenW'(2)) begin
							do_seg = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - LenW'(1);
					if (skip_q == LenW'(1)) begin
						do_seg = 1'b1;
					end
				end
				PH_ENTROPY: begin
					if (b == B_FF) begin
						phase_d = PH_ENTROPY_FF;
					end
				end
				PH_ENTROPY_FF: begin
					if (b == B_00 || (b inside {[M_RST0:M_RST7]})) begin
						phase_d = PH_ENTROPY;
					end else if (b != B_FF) begin
						do_marker = 1'b1;
					end
				end
				default: begin
					give    = 1'b1;
					give_st = ST_INVALID;
				end
			endcase
		end

		if (do_marker) begin
			if (b == M_EOI) begin
				give = 1'b1;
				if (!frame_q || (prog_q && count_q == '0)) begin
					give_st = ST_INVALID;
				end else begin
					give_st = ST_OK;
					give_pr = prog_q;
				end
			end else if (b == M_SOI || (b inside {[M_RST0:M_RST7]})) begin
				give    = 1'b1;
				give_st = ST_INVALID;
			end else if (b == M_TEM) begin
				phase_d = PH_MARK_FF;
			end else if (b < M_SOF0) begin
				give    = 1'b1;
				give_st = ST_INVALID;
			end else begin
				marker_d = b;
				phase_d  = PH_LEN_HI;
			end
		end

		if (do_seg) begin
			if (is_frame_code(marker_q)) begin
				if (frame_q) begin
					give    = 1'b1;
					give_st = ST_INVALID;
				end else begin
					frame_d = 1'b1;
					prog_d  = is_prog_code(marker_q);
					if (!is_prog_code(marker_q)) begin
						give    = 1'b1;
						give_st = ST_OK;
					end else begin
						phase_d = PH_MARK_FF;
					end
				end
			end else if (marker_q == M_SOS) begin
				if (!frame_q) begin
					give    = 1'b1;
					give_st = ST_INVALID;
				end else begin
					count_d = count_inc;
					if (count_inc > {1'b0, scan_limit}) begin
						give    = 1'b1;
						give_st = ST_SCAN_LIMIT;
					end else begin
						phase_d = PH_ENTROPY;
					end
				end
			end else begin
				phase_d = PH_MARK_FF;
			end
		end
	end

	// A file that ends before any decision is reported as invalid.
	assign res_valid       = fire && (give || (item.last_byte && !decided_q));
	assign res.status      = give ? give_st : ST_INVALID;
	assign res.progressive = give && give_pr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SOI_FF;
			marker_q  <= '0;
			len_hi_q  <= '0;
			skip_q    <= '0;
			count_q   <= '0;
			frame_q   <= 1'b0;
			prog_q    <= 1'b0;
			decided_q <= 1'b0;
		end else if (fire) begin
			if (item.last_byte) begin
				phase_q   <= PH_SOI_FF;
				marker_q  <= '0;
				len_hi_q  <= '0;
				skip_q    <= '0;
				count_q   <= '0;
				frame_q   <= 1'b0;
				prog_q    <= 1'b0;
				decided_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				marker_q  <= marker_d;
				len_hi_q  <= len_hi_d;
				skip_q    <= skip_d;
				count_q   <= count_d;
				frame_q   <= frame_d;
				prog_q    <= prog_d;
				decided_q <= decided_q || give;
			end
		end
	end

endmodule

[rtl/core/jmlc_out_fifo.sv]
`timescale 1ns / 1ps

module jmlc_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jmlc_pkg::result_t push_word,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output jmlc_pkg::result_t out_word
);
	import jmlc_pkg::*;

	result_t    mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       pop;

	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid && out_ready;
	// Two entries keep the input side moving while one word waits downstream.
	assign room      = count_q != 2'd2 || pop;
	assign out_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[rtl/core/jpeg_marker_layout_checker.sv]
`timescale 1ns / 1ps

// Checks the marker structure of JPEG files streamed in one byte per word, with
// s_tlast on the final byte of each file, and returns one word per file: ok
// (with the progressive flag), invalid, or scan limit exceeded. Bytes after a
// decision are discarded up to and including the last byte. The block takes one
// byte per cycle when the result buffer has room; a byte is registered at the
// input and the marker state machine updates on it when the result buffer has
// room, and a two-word result buffer lets input continue while a result waits.
// The scan limit register may be written only while the block is idle and
// resets to 500.
module jpeg_marker_layout_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,     // [7:0] data_byte
	input  logic                         s_tlast,     // last_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,     // [1:0] status, [2] progressive
	input  logic                         cfg_wr_en,
	input  logic [jmlc_pkg::LimitW-1:0]  cfg_wr_data  // scan_limit
);
	import jmlc_pkg::*;

	logic [LimitW-1:0] scan_limit_q;
	in_item_t          in_item;
	in_item_t          item_s1;
	logic              valid_s1;
	logic              room;
	logic              fire;
	logic              res_valid;
	result_t           res;
	result_t           out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= ScanLimitReset;
		end else if (cfg_wr_en) begin
			scan_limit_q <= cfg_wr_data;
		end
	end

	assign in_item.data_byte = s_tdata;
	assign in_item.last_byte = s_tlast;
	assign fire              = valid_s1 && room;

	jmlc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.consume  (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jmlc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.scan_limit (scan_limit_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	jmlc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_word (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	assign m_tdata = {5'd0, out_word.progressive, out_word.status};

endmodule

[test/jpeg_marker_layout_checker_tb.sv]
`timescale 1ns / 1ps

module jpeg_marker_layout_checker_tb;
	import jmlc_pkg::*;

	localparam int unsigned CycleLimit   = 500000;
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned HoldCycles   = 120;
	localparam int unsigned MaxReports   = 10;

	localparam logic [7:0] M_APP1 = 8'hE1;
	localparam logic [7:0] M_COM  = 8'hFE;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;
	logic              cfg_wr_en;
	logic [LimitW-1:0] cfg_wr_data;

	jpeg_marker_layout_checker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the layout checker state.
	phase_t            img_phase;
	logic [7:0]        seg_marker;
	logic [7:0]        len_high;
	logic [15:0]       skip_left;
	logic [CountW-1:0] scan_count;
	logic              frame_seen;
	logic              prog_frame;
	logic              decided;
	logic [LimitW-1:0] scan_limit;
	logic [1:0]        verdict_status;
	logic              verdict_prog;
	result_t           verdict_q[$];

	logic [7:0]  img[$];
	int unsigned sent_bytes;
	int unsigned mismatches;
	int unsigned hold_ticket;
	bit          steady;

	function automatic void clear_image();
		img_phase  = PH_SOI_FF;
		seg_marker = '0;
		len_high   = '0;
		skip_left  = '0;
		scan_count = '0;
		frame_seen = 1'b0;
		prog_frame = 1'b0;
		decided    = 1'b0;
	endfunction

	function automatic bit is_sof(input logic [7:0] m);
		return m >= M_SOF0 && m <= M_SOF15 && m != M_DHT && m != M_JPG && m != M_DAC;
	endfunction

	function automatic bit is_prog_sof(input logic [7:0] m);
		return m == M_SOF2 || m == M_SOF6 || m == M_SOF10 || m == M_SOF14;
	endfunction

	function automatic bit is_restart(input logic [7:0] m);
		return m >= M_RST0 && m <= M_RST7;
	endfunction

	function automatic bit give_verdict(input logic [1:0] st, input logic pr);
		verdict_status = st;
		verdict_prog   = pr;
		return 1'b1;
	endfunction

	function automatic bit segment_verdict();
		if (is_sof(seg_marker)) begin
			if (frame_seen)
				return give_verdict(ST_INVALID, 1'b0);
			frame_seen = 1'b1;
			prog_frame = is_prog_sof(seg_marker);
			if (!prog_frame)
				return give_verdict(ST_OK, 1'b0);
		end
		if (seg_marker == M_SOS) begin
			if (!frame_seen)
				return give_verdict(ST_INVALID, 1'b0);
			scan_count = scan_count + 1'b1;
			if (scan_count > scan_limit)
				return give_verdict(ST_SCAN_LIMIT, 1'b0);
			img_phase = PH_ENTROPY;
			return 1'b0;
		end
		img_phase = PH_MARK_FF;
		return 1'b0;
	endfunction

	function automatic bit marker_verdict(input logic [7:0] m);
		if (m == M_EOI) begin
			if (!frame_seen || (prog_frame && scan_count == 0))
				return give_verdict(ST_INVALID, 1'b0);
			return give_verdict(ST_OK, prog_frame);
		end
		if (m == M_SOI || is_restart(m))
			return give_verdict(ST_INVALID, 1'b0);
		if (m == M_TEM) begin
			img_phase = PH_MARK_FF;
			return 1'b0;
		end
		if (m < M_SOF0)
			return give_verdict(ST_INVALID, 1'b0);
		seg_marker = m;
		img_phase  = PH_LEN_HI;
		return 1'b0;
	endfunction

	function automatic bit byte_verdict(input logic [7:0] b);
		logic [15:0] seg_len;
		case (img_phase)
			PH_SOI_FF: begin
				if (scan_limit == 0 || b != B_FF)
					return give_verdict(ST_INVALID, 1'b0);
				img_phase = PH_SOI_CODE;
				return 1'b0;
			end
			PH_SOI_CODE: begin
				if (b == B_FF)
					return 1'b0;
				if (b != M_SOI)
					return give_verdict(ST_INVALID, 1'b0);
				img_phase = PH_MARK_FF;
				return 1'b0;
			end
			PH_MARK_FF: begin
				if (b != B_FF)
					return give_verdict(ST_INVALID, 1'b0);
				img_phase = PH_MARK_CODE;
				return 1'b0;
			end
			PH_MARK_CODE: begin
				if (b == B_FF)
					return 1'b0;
				if (b == B_00)
					return give_verdict(ST_INVALID, 1'b0);
				return marker_verdict(b);
			end
			PH_LEN_HI: begin
				len_high  = b;
				img_phase = PH_LEN_LO;
				return 1'b0;
			end
			PH_LEN_LO: begin
				seg_len = {len_high, b};
				if (seg_len < 16'd2)
					return give_verdict(ST_INVALID, 1'b0);
				skip_left = seg_len - 16'd2;
				if (skip_left == 0)
					return segment_verdict();
				img_phase = PH_SKIP;
				return 1'b0;
			end
			PH_SKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 0)
					return segment_verdict();
				return 1'b0;
			end
			PH_ENTROPY: begin
				if (b == B_FF)
					img_phase = PH_ENTROPY_FF;
				return 1'b0;
			end
			PH_ENTROPY_FF: begin
				if (b == B_FF)
					return 1'b0;
				if (b == B_00 || is_restart(b)) begin
					img_phase = PH_ENTROPY;
					return 1'b0;
				end
				return marker_verdict(b);
			end
			default: return give_verdict(ST_INVALID, 1'b0);
		endcase
	endfunction

	function automatic void predict_verdict(input logic [7:0] b, input logic last);
		result_t r;
		sent_bytes++;
		if (!decided) begin
			if (byte_verdict(b)) begin
				decided       = 1'b1;
				r.status      = verdict_status;
				r.progressive = verdict_prog;
				verdict_q.push_back(r);
			end
		end
		if (last) begin
			// A file that ends before any decision is truncated.
			if (!decided) begin
				r.status      = ST_INVALID;
				r.progressive = 1'b0;
				verdict_q.push_back(r);
			end
			clear_image();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < 25) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_verdict(b, last);
		@(negedge clk);
	endtask

	task automatic send_image();
		for (int i = 0; i < img.size(); i++)
			send_byte(img[i], i == img.size() - 1);
		img.delete();
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		// Bytes after a decision leave no result, so give the pipeline time to empty.
		repeat (SettleCycles)
			@(negedge clk);
	endtask

	task automatic write_scan_limit(input logic [LimitW-1:0] v);
		wait_idle();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en  = 1'b0;
		scan_limit = v;
	endtask

	task automatic put_marker(input logic [7:0] code);
		img.push_back(B_FF);
		if ($urandom_range(9) == 0)
			img.push_back(B_FF);
		img.push_back(code);
	endtask

	task automatic put_segment(input logic [7:0] code);
		int unsigned n;
		n = ($urandom_range(29) == 0) ? $urandom_range(300, 9) : $urandom_range(8, 0);
		put_marker(code);
		img.push_back(8'((n + 2) >> 8));
		img.push_back(8'(n + 2));
		repeat (n)
			img.push_back(8'($urandom));
	endtask

	task automatic put_entropy();
		logic [7:0] b;
		repeat ($urandom_range(12, 0)) begin
			b = ($urandom_range(4) == 0) ? B_FF : 8'($urandom);
			img.push_back(b);
			// Every 0xFF inside entropy data is followed by stuffing or a restart.
			if (b == B_FF) begin
				if ($urandom_range(3) == 0)
					img.push_back(B_FF);
				if ($urandom_range(1) == 0)
					img.push_back(B_00);
				else
					img.push_back(M_RST0 + 8'($urandom_range(7)));
			end
		end
	endtask

	function automatic logic [7:0] table_code();
		logic [7:0] c;
		c = 8'($urandom_range(M_COM, M_SOF0));
		if (is_sof(c) || (c >= M_RST0 && c <= M_SOS))
			c = M_DHT;
		return c;
	endfunction

	function automatic logic [7:0] frame_code(input bit prog);
		logic [7:0] c;
		do
			c = 8'($urandom_range(M_SOF15, M_SOF0));
		while (!is_sof(c) || is_prog_sof(c) != prog);
		return c;
	endfunction

	task automatic build_image();
		int unsigned kind;
		int unsigned scans;
		int unsigned keep;
		img.delete();
		img.push_back(B_FF);
		if ($urandom_range(7) == 0)
			img.push_back(B_FF);
		img.push_back(M_SOI);
		repeat ($urandom_range(2)) begin
			if ($urandom_range(5) == 0)
				put_marker(M_TEM);
			else
				put_segment(table_code());
		end
		kind = $urandom_range(9);
		if (kind < 3)
			put_segment(frame_code(1'b0));
		else if (kind < 9)
			put_segment(frame_code(1'b1));
		scans = (kind < 3) ? 0 : (kind < 9) ? $urandom_range(4, 1) : $urandom_range(1);
		repeat (scans) begin
			if ($urandom_range(3) == 0)
				put_segment(table_code());
			put_segment(M_SOS);
			put_entropy();
		end
		put_marker(M_EOI);
		repeat ($urandom_range(3))
			img.push_back(8'($urandom));
		case ($urandom_range(9))
			7: img[$urandom_range(img.size() - 1)] = 8'($urandom);
			8: begin
				keep = $urandom_range(img.size(), 1);
				while (img.size() > keep)
					img.delete(img.size() - 1);
			end
			9: begin
				img.delete();
				if ($urandom_range(1) == 0)
					img = {B_FF, M_SOI};
				repeat ($urandom_range(20, 1))
					img.push_back(8'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic test_start_rules();
		img = {B_00};
		send_image();
		img = {B_FF};
		send_image();
		img = {B_FF, B_FF, M_EOI};
		send_image();
		img = {B_FF, M_SOI, 8'h12};
		send_image();
		img = {B_FF, M_SOI, B_FF, B_00};
		send_image();
	endtask

	task automatic test_marker_rules();
		img = {B_FF, M_SOI, B_FF, M_TEM, B_FF, B_FF, M_EOI};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_RST0};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOI};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOF0 - 8'd1};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_DHT, 8'h00, 8'h01, B_FF};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_DHT, 8'h00, 8'h00};
		send_image();
	endtask

	task automatic test_segment_rules();
		img = {B_FF, M_SOI, B_FF, M_SOF2, 8'h00, 8'h02, B_FF, M_SOF0, 8'h00, 8'h02};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOF15, 8'h00, 8'h03, 8'h7F, B_00, B_FF, 8'h55};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOS, 8'h00, 8'h02};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOF14, 8'h00, 8'h02, B_FF, M_EOI};
		send_image();
		// The decision on the final byte wins over truncation.
		img = {B_FF, B_FF, M_SOI, B_FF, M_SOF0, 8'h00, 8'h02};
		send_image();
	endtask

	task automatic test_entropy_rules();
		img = {B_FF, M_SOI, B_FF, M_SOF10, 8'h00, 8'h02, B_FF, M_SOS, 8'h00, 8'h03, 8'hA5,
			B_FF, B_00, 8'h5A, B_FF, B_FF, M_RST7, B_FF, M_EOI};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOF6, 8'h00, 8'h02, B_FF, M_SOS, 8'h00, 8'h02, 8'h11};
		send_image();
		img = {B_FF, M_SOI, B_FF, M_SOF2, 8'h00, 8'h02, B_FF, M_SOS, 8'h00, 8'h02, 8'h22,
			B_FF, M_SOI, 8'h33};
		send_image();
	endtask

	task automatic send_two_scans();
		img = {B_FF, M_SOI, B_FF, M_SOF2, 8'h00, 8'h02, B_FF, M_SOS, 8'h00, 8'h02, 8'h33,
			B_FF, M_SOS, 8'h00, 8'h02, 8'h44, B_FF, M_EOI};
		send_image();
	endtask

	task automatic test_scan_limit();
		write_scan_limit('0);
		img = {B_FF, M_SOI, B_FF, M_SOF0, 8'h00, 8'h02};
		send_image();
		write_scan_limit(LimitW'(1));
		send_two_scans();
		write_scan_limit('1);
		send_two_scans();
	endtask

	task automatic test_long_segment();
		img = {B_FF, M_SOI, B_FF, M_APP1, 8'h01, 8'h03};
		repeat (16'h0103 - 2)
			img.push_back(8'($urandom));
		img = {img, B_FF, M_SOF0, 8'h00, 8'h02};
		send_image();
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_ticket++;
		// One-word files each give a result, so the result buffer fills during the hold.
		repeat (24) begin
			img = {B_00};
			send_image();
		end
		wait_idle();
	endtask

	task automatic test_random_layouts(input logic [LimitW-1:0] lim, input int unsigned n_bytes,
		input bit no_idle);
		int unsigned stop_at;
		write_scan_limit(lim);
		steady  = no_idle;
		stop_at = sent_bytes + n_bytes;
		while (sent_bytes < stop_at) begin
			build_image();
			send_image();
		end
		steady = 1'b0;
	endtask

	initial begin : result_sink
		int unsigned hold_left;
		int unsigned served;
		hold_left = 0;
		served    = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (served != hold_ticket) begin
				served    = hold_ticket;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = steady || $urandom_range(99) >= 25;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				if (mismatches < MaxReports)
					$display("unexpected result word: status %0d progressive %0d",
						m_tdata[1:0], m_tdata[2]);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[1:0] !== want.status || m_tdata[2] !== want.progressive) begin
					if (mismatches < MaxReports)
						$display("mismatch: want status %0d prog %0d, got status %0d prog %0d",
							want.status, want.progressive, m_tdata[1:0], m_tdata[2]);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("** jpeg_marker_layout_checker: FAILED **");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		steady      = 1'b0;
		hold_ticket = 0;
		mismatches  = 0;
		sent_bytes  = 0;
		scan_limit  = ScanLimitReset;
		clear_image();
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_start_rules();
		test_marker_rules();
		test_segment_rules();
		test_entropy_rules();
		test_scan_limit();
		test_long_segment();
		test_backpressure();
		test_random_layouts(LimitW'(1023), 260, 1'b0);
		test_random_layouts(LimitW'(2), 180, 1'b1);
		test_random_layouts(LimitW'(1), 180, 1'b0);
		test_random_layouts(LimitW'(0), 30, 1'b0);
		test_random_layouts(LimitW'($urandom_range(1023)), 180, 1'b0);
		test_random_layouts(LimitW'($urandom_range(4, 1)), 220, 1'b0);

		wait_idle();
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("** jpeg_marker_layout_checker: PASSED **");
		else
			$display("** jpeg_marker_layout_checker: FAILED **");
		$finish;
	end

endmodule
